// File: hdl/rot4p_pkg.sv
package rot4p_pkg;

    // Port field widths
    localparam int COORD_W    = 16;
    localparam int IDX_W      = 4;
    localparam int PHASE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CENTRE_W   = 12;

    // Internal datapath widths
    localparam int SINE_W  = 16;  // signed Q2.14 sine/cosine
    localparam int CW      = 20;  // rotated coordinate, signed Q20.0 integer
    localparam int RW      = 40;  // rotation accumulator
    localparam int MW      = 22;  // shared multiplier operand, signed
    localparam int PW      = 2 * MW;
    localparam int DNW     = 62;  // dividend / quotient
    localparam int DSW     = 42;  // divisor
    localparam int DW      = 43;  // signed perspective denominator
    localparam int P3W     = 42;  // projected coordinate, signed
    localparam int MAGW    = 41;  // magnitude operand split in two halves
    localparam int SPLIT   = 21;  // low half width of a split magnitude
    localparam int SVW     = 60;  // signed pixel product
    localparam int PIX_SHIFT = 20;

    localparam logic [14:0] SINE_ONE = 15'd16384;
    localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;

    // Reset values of the configuration registers
    localparam logic [15:0] RESET_STEP  = 16'd100;
    localparam logic [15:0] RESET_FOV   = 16'd512;
    localparam logic [15:0] RESET_SCALE = 16'd25600;
    localparam logic [CENTRE_W-1:0] RESET_CENTRE_X = 12'd400; // 800 / 2
    localparam logic [CENTRE_W-1:0] RESET_CENTRE_Y = 12'd300; // 600 / 2

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_OF_VIEW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y      = 3'd4;

    // Command codes
    localparam logic CMD_VERTEX = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIG,
        ST_ROT,
        ST_CHK1,
        ST_PM1,
        ST_DIV1,
        ST_CHK2,
        ST_PM2,
        ST_DIV2,
        ST_PX,
        ST_DONE
    } rot4p_state_t;

    // Quarter-wave sine in Q2.14, sin(k*pi/32)
    function automatic logic [14:0] sine_quarter(input logic [4:0] k);
        logic [14:0] v;
        case (k)
            5'd0:    v = 15'd0;
            5'd1:    v = 15'd1606;
            5'd2:    v = 15'd3196;
            5'd3:    v = 15'd4756;
            5'd4:    v = 15'd6270;
            5'd5:    v = 15'd7723;
            5'd6:    v = 15'd9102;
            5'd7:    v = 15'd10394;
            5'd8:    v = 15'd11585;
            5'd9:    v = 15'd12665;
            5'd10:   v = 15'd13623;
            5'd11:   v = 15'd14449;
            5'd12:   v = 15'd15137;
            5'd13:   v = 15'd15679;
            5'd14:   v = 15'd16069;
            5'd15:   v = 15'd16305;
            default: v = SINE_ONE;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/rot4p_if.sv
interface rot4p_vertex_if import rot4p_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [IDX_W-1:0]          vertex_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic signed [COORD_W-1:0] coord_w;

    modport source (output valid, cmd, vertex_index, coord_x, coord_y, coord_z, coord_w,
                    input ready);
    modport sink (input valid, cmd, vertex_index, coord_x, coord_y, coord_z, coord_w,
                  output ready);
endinterface

interface rot4p_pixel_if import rot4p_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [IDX_W-1:0]          out_index;
    logic signed [COORD_W-1:0] screen_x;
    logic signed [COORD_W-1:0] screen_y;
    logic                      behind_viewer;

    modport source (output valid, out_index, screen_x, screen_y, behind_viewer,
                    input ready);
    modport sink (input valid, out_index, screen_x, screen_y, behind_viewer,
                  output ready);
endinterface

// File: hdl/rot4p_sine.sv
module rot4p_sine import rot4p_pkg::*;
(
    input  logic [PHASE_W-1:0]       phase,
    output logic signed [SINE_W-1:0] value
);

    logic [1:0]  quad;
    logic [14:0] off;
    logic [4:0]  idx;
    logic [9:0]  frac;
    logic [14:0] t0;
    logic [14:0] t1;
    logic [24:0] slope;
    logic [14:0] mag;

    always_comb
    begin
        quad = phase[15:14];
        // mirror the offset in the second and fourth quadrant
        if (quad[0])
        begin
            off = QUARTER_TURN[14:0] - {1'b0, phase[13:0]};
        end
        else
        begin
            off = {1'b0, phase[13:0]};
        end
        idx   = off[14:10];
        frac  = off[9:0];
        t0    = sine_quarter(idx);
        t1    = sine_quarter(idx + 5'd1);
        slope = {10'd0, t1 - t0} * {15'd0, frac};
        if (idx[4])
        begin
            mag = SINE_ONE;
        end
        else
        begin
            mag = t0 + slope[24:10];
        end
        if (quad[1])
        begin
            value = -$signed({1'b0, mag});
        end
        else
        begin
            value = $signed({1'b0, mag});
        end
    end

endmodule

// File: hdl/rot4p_muldiv.sv
module rot4p_muldiv import rot4p_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic signed [MW-1:0] mul_a,
    input  logic signed [MW-1:0] mul_b,
    output logic signed [PW-1:0] product,
    input  logic                 div_start,
    input  logic [DNW-1:0]       dividend,
    input  logic [DSW-1:0]       divisor,
    output logic                 div_done,
    output logic [DNW-1:0]       quotient
);

    localparam int CNTW = $clog2(DNW);

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic [DNW-1:0]       quo_reg;
    logic [DNW-1:0]       quo_next;
    logic [DSW-1:0]       rem_reg;
    logic [DSW-1:0]       rem_next;
    logic [DSW-1:0]       dsr_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic [CNTW-1:0]      cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DSW:0]         trial;

    assign prod_next = PW'(mul_a) * PW'(mul_b);

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DNW-1]};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (div_start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNTW'(DNW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = DSW'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[DNW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DSW-1:0];
                quo_next = {quo_reg[DNW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        if (div_start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign product  = prod_reg;
    assign div_done = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hdl/rotate4d_project_vertex.sv
// A tick word is absorbed in the cycle it is accepted. A vertex word runs through the
// sequencer, whose run is set by the one-bit-per-cycle shared divider (up to five 62-bit
// divisions) and the single shared multiplier; its result arrives sooner when it lands
// behind the viewer. No new word is taken while a vertex is in flight; the next word is
// taken once the result is parked. Reset (rst_n, async, active low) zeroes the angles and
// loads register defaults.
module rotate4d_project_vertex import rot4p_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rot4p_vertex_if.sink          vertex,
    rot4p_pixel_if.source         pixel,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic signed [RW-1:0]  ROT_HALF = RW'(8192);
    localparam logic signed [SVW-1:0] PIX_HALF = SVW'(1 << 19);
    localparam logic [DNW-1:0]        MAG_LIMIT = DNW'(64'd1 << 40);
    localparam logic signed [SVW-1:0] SAT_HI = SVW'(32767);
    localparam logic signed [SVW-1:0] SAT_LO = -SVW'(32768);

    // Sequencer state
    rot4p_state_t state_reg, state_next;
    logic [2:0]   plane_reg, plane_next;   // rotation plane xy..zw
    logic [2:0]   sub_reg, sub_next;       // step within one operation
    logic [1:0]   sel_reg, sel_next;       // coordinate being projected

    // Configuration and angles
    logic [15:0]         step_reg, fov_reg, scale_reg;
    logic [CENTRE_W-1:0] cx_reg, cy_reg;
    logic [PHASE_W-1:0]  angle_reg [6];
    logic [PHASE_W-1:0]  angle_next [6];

    // Datapath registers
    logic signed [CW-1:0]     x_reg, x_next, y_reg, y_next, z_reg, z_next, w_reg, w_next;
    logic signed [SINE_W-1:0] sin_reg, sin_next, cos_reg, cos_next;
    logic signed [RW-1:0]     acc_reg, acc_next;
    logic signed [CW-1:0]     tmp_reg, tmp_next;
    logic signed [DW-1:0]     d_reg, d_next;
    logic signed [P3W-1:0]    x3_reg, x3_next, y3_reg, y3_next, z3_reg, z3_next;
    logic [MAGW-1:0]          mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic [DNW-1:0]           big_reg, big_next;
    logic [COORD_W-1:0]       sx_reg, sx_next, sy_reg, sy_next;
    logic                     flag_reg, flag_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]   out_index_reg, out_index_next;
    logic [COORD_W-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic               out_flag_reg, out_flag_next;

    // Shared unit connections
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] product;
    logic                 div_start, div_done;
    logic [DNW-1:0]       div_dividend, quotient;

    // Helpers
    logic [PHASE_W-1:0]       sin_phase, cos_phase;
    logic signed [SINE_W-1:0] sin_val, cos_val;
    logic signed [CW-1:0]     rot_a, rot_b;
    logic signed [RW-1:0]     prod_r;
    logic signed [PW-1:0]     prod_abs;
    logic [19:0]              fov16;
    logic signed [DW-1:0]     d1, d2;
    logic [DNW-1:0]           prod_u, sum_u;
    logic signed [SVW-1:0]    sv, pix;
    logic [COORD_W-1:0]       pix_sat;
    logic signed [P3W-1:0]    q_signed;
    logic [CENTRE_W-1:0]      centre;

    function automatic logic signed [CW-1:0] round14(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] t;
        t = (v + ROT_HALF) >>> 14;
        return t[CW-1:0];
    endfunction

    rot4p_sine u_sin
    (
        .phase (sin_phase),
        .value (sin_val)
    );

    rot4p_sine u_cos
    (
        .phase (cos_phase),
        .value (cos_val)
    );

    rot4p_muldiv u_muldiv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .product   (product),
        .div_start (div_start),
        .dividend  (div_dividend),
        .divisor   (d_reg[DSW-1:0]),
        .div_done  (div_done),
        .quotient  (quotient)
    );

    assign sin_phase = angle_reg[plane_reg];
    assign cos_phase = sin_phase + QUARTER_TURN;
    assign fov16     = {fov_reg, 4'd0};
    assign prod_r    = $signed(product[RW-1:0]);
    assign prod_abs  = product[PW-1] ? -product : product;
    assign prod_u    = DNW'($unsigned(product));
    assign sum_u     = big_reg + prod_u;
    assign d1        = DW'($signed({1'b0, fov16})) + DW'(w_reg);
    assign d2        = DW'($signed({1'b0, fov16})) + DW'(z3_reg);
    assign q_signed  = neg_reg ? -$signed({1'b0, quotient[P3W-2:0]})
                               : $signed({1'b0, quotient[P3W-2:0]});
    assign centre    = (sel_reg == 2'd0) ? cx_reg : cy_reg;

    // Pixel: apply sign, round by floor shift, add centre, saturate
    always_comb
    begin
        sv  = neg_reg ? -SVW'(sum_u) : SVW'(sum_u);
        pix = ((sv + PIX_HALF) >>> PIX_SHIFT) + SVW'($signed({1'b0, centre}));
        if (pix > SAT_HI)
        begin
            pix_sat = 16'h7FFF;
        end
        else if (pix < SAT_LO)
        begin
            pix_sat = 16'h8000;
        end
        else
        begin
            pix_sat = pix[COORD_W-1:0];
        end
    end

    // Coordinate pair of the current rotation plane
    always_comb
    begin
        case (plane_reg)
            3'd0:    begin rot_a = x_reg; rot_b = y_reg; end
            3'd1:    begin rot_a = x_reg; rot_b = z_reg; end
            3'd2:    begin rot_a = x_reg; rot_b = w_reg; end
            3'd3:    begin rot_a = y_reg; rot_b = z_reg; end
            3'd4:    begin rot_a = y_reg; rot_b = w_reg; end
            default: begin rot_a = z_reg; rot_b = w_reg; end
        endcase
    end

    // Multiplier operand select; the product is registered and shows up in the next cycle
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_ROT:
            begin
                case (sub_reg)
                    3'd0:    begin mul_a = MW'(rot_a); mul_b = MW'(cos_reg); end
                    3'd1:    begin mul_a = MW'(rot_b); mul_b = MW'(sin_reg); end
                    3'd2:    begin mul_a = MW'(rot_a); mul_b = MW'(sin_reg); end
                    default: begin mul_a = MW'(rot_b); mul_b = MW'(cos_reg); end
                endcase
            end
            ST_PM1:
            begin
                case (sel_reg)
                    2'd0:    mul_a = MW'(x_reg);
                    2'd1:    mul_a = MW'(y_reg);
                    default: mul_a = MW'(z_reg);
                endcase
                mul_b = $signed({2'b00, fov16});
            end
            ST_PM2:
            begin
                if (sub_reg == 3'd0)
                begin
                    mul_a = $signed({2'b00, mag_reg[MAGW-1:SPLIT]});
                end
                else
                begin
                    mul_a = $signed({1'b0, mag_reg[SPLIT-1:0]});
                end
                mul_b = $signed({2'b00, fov16});
            end
            ST_PX:
            begin
                if (sub_reg == 3'd0)
                begin
                    mul_a = $signed({2'b00, mag_reg[MAGW-1:SPLIT]});
                end
                else
                begin
                    mul_a = $signed({1'b0, mag_reg[SPLIT-1:0]});
                end
                mul_b = $signed({6'd0, scale_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_dividend = (state_reg == ST_PM1) ? DNW'($unsigned(prod_abs)) : sum_u;

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        plane_next     = plane_reg;
        sub_next       = sub_reg;
        sel_next       = sel_reg;
        angle_next     = angle_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        w_next         = w_reg;
        sin_next       = sin_reg;
        cos_next       = cos_reg;
        acc_next       = acc_reg;
        tmp_next       = tmp_reg;
        d_next         = d_reg;
        x3_next        = x3_reg;
        y3_next        = y3_reg;
        z3_next        = z3_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        big_next       = big_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        flag_next      = flag_reg;
        idx_next       = idx_reg;
        div_start      = 1'b0;
        // drop the pending result once it is taken
        out_valid_next = out_valid_reg && !pixel.ready;
        out_index_next = out_index_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_flag_next  = out_flag_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (vertex.valid)
                begin
                    if (vertex.cmd == CMD_TICK)
                    begin
                        for (int i = 0; i < 6; i++)
                        begin
                            angle_next[i] = angle_reg[i] + step_reg;
                        end
                    end
                    else
                    begin
                        x_next     = CW'(vertex.coord_x);
                        y_next     = CW'(vertex.coord_y);
                        z_next     = CW'(vertex.coord_z);
                        w_next     = CW'(vertex.coord_w);
                        idx_next   = vertex.vertex_index;
                        flag_next  = 1'b0;
                        plane_next = 3'd0;
                        state_next = ST_TRIG;
                    end
                end
            end
            ST_TRIG:
            begin
                sin_next   = sin_val;
                cos_next   = cos_val;
                sub_next   = 3'd0;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                case (sub_reg)
                    3'd0:
                    begin
                        sub_next = 3'd1;
                    end
                    3'd1:
                    begin
                        acc_next = prod_r;
                        sub_next = 3'd2;
                    end
                    3'd2:
                    begin
                        tmp_next = round14(acc_reg - prod_r);
                        sub_next = 3'd3;
                    end
                    3'd3:
                    begin
                        acc_next = prod_r;
                        sub_next = 3'd4;
                    end
                    default:
                    begin
                        case (plane_reg)
                            3'd0:    begin x_next = tmp_reg; y_next = round14(acc_reg + prod_r); end
                            3'd1:    begin x_next = tmp_reg; z_next = round14(acc_reg + prod_r); end
                            3'd2:    begin x_next = tmp_reg; w_next = round14(acc_reg + prod_r); end
                            3'd3:    begin y_next = tmp_reg; z_next = round14(acc_reg + prod_r); end
                            3'd4:    begin y_next = tmp_reg; w_next = round14(acc_reg + prod_r); end
                            default: begin z_next = tmp_reg; w_next = round14(acc_reg + prod_r); end
                        endcase
                        if (plane_reg == 3'd5)
                        begin
                            state_next = ST_CHK1;
                        end
                        else
                        begin
                            plane_next = plane_reg + 3'd1;
                            state_next = ST_TRIG;
                        end
                    end
                endcase
            end
            ST_CHK1:
            begin
                if (d1[DW-1] || d1 == '0)
                begin
                    flag_next  = 1'b1;
                    sx_next    = '0;
                    sy_next    = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    d_next     = d1;
                    sel_next   = 2'd0;
                    sub_next   = 3'd0;
                    state_next = ST_PM1;
                end
            end
            ST_PM1:
            begin
                if (sub_reg == 3'd0)
                begin
                    sub_next = 3'd1;
                end
                else
                begin
                    div_start  = 1'b1;
                    neg_next   = product[PW-1];
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    case (sel_reg)
                        2'd0:    x3_next = q_signed;
                        2'd1:    y3_next = q_signed;
                        default: z3_next = q_signed;
                    endcase
                    if (sel_reg == 2'd2)
                    begin
                        state_next = ST_CHK2;
                    end
                    else
                    begin
                        sel_next   = sel_reg + 2'd1;
                        sub_next   = 3'd0;
                        state_next = ST_PM1;
                    end
                end
            end
            ST_CHK2:
            begin
                if (d2[DW-1] || d2 == '0)
                begin
                    flag_next  = 1'b1;
                    sx_next    = '0;
                    sy_next    = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    d_next     = d2;
                    neg_next   = x3_reg[P3W-1];
                    mag_next   = x3_reg[P3W-1] ? MAGW'(-x3_reg) : MAGW'(x3_reg);
                    sel_next   = 2'd0;
                    sub_next   = 3'd0;
                    state_next = ST_PM2;
                end
            end
            ST_PM2:
            begin
                case (sub_reg)
                    3'd0:
                    begin
                        sub_next = 3'd1;
                    end
                    3'd1:
                    begin
                        big_next = {product[DNW-SPLIT-1:0], SPLIT'(0)};
                        sub_next = 3'd2;
                    end
                    default:
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV2;
                    end
                endcase
            end
            ST_DIV2:
            begin
                if (div_done)
                begin
                    // hold the magnitude at 2^40; the saturated pixel is the same
                    if (quotient > MAG_LIMIT)
                    begin
                        mag_next = MAG_LIMIT[MAGW-1:0];
                    end
                    else
                    begin
                        mag_next = quotient[MAGW-1:0];
                    end
                    sub_next   = 3'd0;
                    state_next = ST_PX;
                end
            end
            ST_PX:
            begin
                case (sub_reg)
                    3'd0:
                    begin
                        sub_next = 3'd1;
                    end
                    3'd1:
                    begin
                        big_next = {product[DNW-SPLIT-1:0], SPLIT'(0)};
                        sub_next = 3'd2;
                    end
                    default:
                    begin
                        if (sel_reg == 2'd0)
                        begin
                            sx_next    = pix_sat;
                            neg_next   = y3_reg[P3W-1];
                            mag_next   = y3_reg[P3W-1] ? MAGW'(-y3_reg) : MAGW'(y3_reg);
                            sel_next   = 2'd1;
                            sub_next   = 3'd0;
                            state_next = ST_PM2;
                        end
                        else
                        begin
                            sy_next    = pix_sat;
                            state_next = ST_DONE;
                        end
                    end
                endcase
            end
            ST_DONE:
            begin
                // park the result once the output register is free
                if (!out_valid_reg || pixel.ready)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = idx_reg;
                    out_x_next     = sx_reg;
                    out_y_next     = sy_reg;
                    out_flag_next  = flag_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            plane_reg     <= '0;
            sub_reg       <= '0;
            sel_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                angle_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            plane_reg     <= plane_next;
            sub_reg       <= sub_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
            angle_reg     <= angle_next;
        end
    end

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= RESET_STEP;
            fov_reg   <= RESET_FOV;
            scale_reg <= RESET_SCALE;
            cx_reg    <= RESET_CENTRE_X;
            cy_reg    <= RESET_CENTRE_Y;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROTATION_STEP: step_reg  <= cfg_data;
                CFG_FIELD_OF_VIEW: fov_reg   <= cfg_data;
                CFG_PIXEL_SCALE:   scale_reg <= cfg_data;
                CFG_CENTRE_X:      cx_reg    <= cfg_data[CENTRE_W-1:0];
                CFG_CENTRE_Y:      cy_reg    <= cfg_data[CENTRE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        w_reg         <= w_next;
        sin_reg       <= sin_next;
        cos_reg       <= cos_next;
        acc_reg       <= acc_next;
        tmp_reg       <= tmp_next;
        d_reg         <= d_next;
        x3_reg        <= x3_next;
        y3_reg        <= y3_next;
        z3_reg        <= z3_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        big_reg       <= big_next;
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        flag_reg      <= flag_next;
        idx_reg       <= idx_next;
        out_index_reg <= out_index_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_flag_reg  <= out_flag_next;
    end

    assign vertex.ready        = (state_reg == ST_IDLE);
    assign pixel.valid         = out_valid_reg;
    assign pixel.out_index     = out_index_reg;
    assign pixel.screen_x      = out_x_reg;
    assign pixel.screen_y      = out_y_reg;
    assign pixel.behind_viewer = out_flag_reg;

endmodule

// File: verif/rot4p_checker.sv
module rot4p_checker import rot4p_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rot4p_vertex_if               vertex,
    rot4p_pixel_if                pixel,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    typedef struct {
        logic [IDX_W-1:0]          index;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic                      behind;
    } pixel_word_t;

    localparam longint QUARTER_SINE [17] = '{
        0, 1606, 3196, 4756, 6270, 7723, 9102, 10394, 11585,
        12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384
    };

    logic [PHASE_W-1:0]  plane_phase [6];
    logic [15:0]         step_reg, fov_reg, scale_reg;
    logic [CENTRE_W-1:0] cx_reg, cy_reg;
    pixel_word_t         pixel_fifo [$];

    function automatic longint phase_sine(logic [PHASE_W-1:0] p);
        logic [14:0] off;
        int          k;
        longint      mag;
        off = {1'b0, p[13:0]};
        if (p[14])
            off = 15'h4000 - off;
        k = off[14:10];
        if (k >= 16)
            mag = QUARTER_SINE[16];
        else
            mag = QUARTER_SINE[k] +
                  (((QUARTER_SINE[k+1] - QUARTER_SINE[k]) * longint'(off[9:0])) >>> 10);
        return p[15] ? -mag : mag;
    endfunction

    function automatic void turn_plane(ref longint a, ref longint b,
                                       input logic [PHASE_W-1:0] p);
        longint s, c, na, nb;
        s  = phase_sine(p);
        c  = phase_sine(p + QUARTER_TURN);
        na = (a * c - b * s + 8192) >>> 14;
        nb = (a * s + b * c + 8192) >>> 14;
        a  = na;
        b  = nb;
    endfunction

    function automatic logic [15:0] screen_coord(longint v, logic [CENTRE_W-1:0] centre);
        longint lim, r;
        lim = longint'(1) << 40;
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        r = ((v * longint'(scale_reg) + (longint'(1) << 19)) >>> 20) + longint'(centre);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    // Rotate through the six planes, then project 4D -> 3D -> 2D.
    function automatic pixel_word_t project_vertex(logic [IDX_W-1:0] index,
            logic signed [15:0] cx, logic signed [15:0] cy,
            logic signed [15:0] cz, logic signed [15:0] cw);
        pixel_word_t res;
        longint x, y, z, w, f, d1, d2, x3, y3, z3;
        x = cx;
        y = cy;
        z = cz;
        w = cw;
        turn_plane(x, y, plane_phase[0]);
        turn_plane(x, z, plane_phase[1]);
        turn_plane(x, w, plane_phase[2]);
        turn_plane(y, z, plane_phase[3]);
        turn_plane(y, w, plane_phase[4]);
        turn_plane(z, w, plane_phase[5]);
        res.index  = index;
        res.sx     = '0;
        res.sy     = '0;
        res.behind = 1'b1;
        f  = longint'(fov_reg) * 16;
        d1 = f + w;
        if (d1 <= 0)
            return res;
        x3 = x * f / d1;
        y3 = y * f / d1;
        z3 = z * f / d1;
        d2 = f + z3;
        if (d2 <= 0)
            return res;
        res.sx     = screen_coord(x3 * f / d2, cx_reg);
        res.sy     = screen_coord(y3 * f / d2, cy_reg);
        res.behind = 1'b0;
        return res;
    endfunction

    task automatic flag_mismatch(string what, pixel_word_t exp_w, pixel_word_t got_w);
        fail_count++;
        if (fail_count <= 10)
            $display("rot4p_checker: %s: expected idx=%0d x=%0d y=%0d behind=%0d, got idx=%0d x=%0d y=%0d behind=%0d",
                     what, exp_w.index, exp_w.sx, exp_w.sy, exp_w.behind,
                     got_w.index, got_w.sx, got_w.sy, got_w.behind);
    endtask

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk or negedge rst_n) begin
        pixel_word_t got_w, exp_w;
        if (!rst_n) begin
            for (int i = 0; i < 6; i++)
                plane_phase[i] = '0;
            step_reg  = RESET_STEP;
            fov_reg   = RESET_FOV;
            scale_reg = RESET_SCALE;
            cx_reg    = RESET_CENTRE_X;
            cy_reg    = RESET_CENTRE_Y;
            pixel_fifo.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ROTATION_STEP: step_reg  = cfg_data;
                    CFG_FIELD_OF_VIEW: fov_reg   = cfg_data;
                    CFG_PIXEL_SCALE:   scale_reg = cfg_data;
                    CFG_CENTRE_X:      cx_reg    = cfg_data[CENTRE_W-1:0];
                    CFG_CENTRE_Y:      cy_reg    = cfg_data[CENTRE_W-1:0];
                    default: ;
                endcase
            end
            // Drain the result side first; the queue keeps order anyway.
            if (pixel.valid && pixel.ready) begin
                got_w.index  = pixel.out_index;
                got_w.sx     = pixel.screen_x;
                got_w.sy     = pixel.screen_y;
                got_w.behind = pixel.behind_viewer;
                if (pixel_fifo.size() == 0) begin
                    exp_w = '{default: '0};
                    flag_mismatch("unexpected word", exp_w, got_w);
                end else begin
                    exp_w = pixel_fifo.pop_front();
                    if (got_w.index !== exp_w.index || got_w.sx !== exp_w.sx ||
                        got_w.sy !== exp_w.sy || got_w.behind !== exp_w.behind)
                        flag_mismatch("mismatch", exp_w, got_w);
                end
            end
            if (vertex.valid && vertex.ready) begin
                if (vertex.cmd == CMD_TICK) begin
                    for (int i = 0; i < 6; i++)
                        plane_phase[i] = plane_phase[i] + step_reg;
                end else begin
                    pixel_fifo.push_back(project_vertex(vertex.vertex_index, vertex.coord_x,
                                                        vertex.coord_y, vertex.coord_z,
                                                        vertex.coord_w));
                end
            end
        end
        pending = pixel_fifo.size();
    end

endmodule

// File: verif/tb_top.sv
module tb_top;
    import rot4p_pkg::*;

    // Settling margin after the last result; it exceeds the time one vertex takes.
    localparam int DRAIN_CYCLES = 600;
    localparam int HOLD_CYCLES  = 2500;
    localparam int IDLE_LIMIT   = 20000;
    localparam int RANDOM_WORDS = 700;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    bit                    hold_request;
    int                    idle_cycles;

    rot4p_vertex_if vtx ();
    rot4p_pixel_if  pix ();

    rotate4d_project_vertex dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vertex    (vtx),
        .pixel     (pix),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rot4p_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .vertex     (vtx),
        .pixel      (pix),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Watchdog: count cycles where neither channel moves a word.
    always @(posedge clk) begin
        if ((vtx.valid && vtx.ready) || (pix.valid && pix.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Receiver: switch stall pattern every so often; honor a long hold-off on request.
    initial begin
        int mode;
        int span;
        pix.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_request) begin
                @(negedge clk);
                pix.ready <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++)
                    @(negedge clk);
                hold_request = 1'b0;
            end
            mode = $urandom_range(3);
            span = $urandom_range(200, 20);
            for (int i = 0; i < span; i++) begin
                @(negedge clk);
                case (mode)
                    0:       pix.ready <= 1'b1;
                    1:       pix.ready <= ($urandom_range(1) == 1);
                    2:       pix.ready <= ($urandom_range(7) == 0);
                    default: pix.ready <= ((i % 8) < 5);
                endcase
            end
        end
    end

    // Hold the word until the block takes it; drop valid only during a gap.
    task automatic send_word(logic cmd, logic [IDX_W-1:0] index, logic [15:0] x,
                             logic [15:0] y, logic [15:0] z, logic [15:0] w, int gap);
        @(negedge clk);
        if (gap > 0) begin
            vtx.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        vtx.cmd          <= cmd;
        vtx.vertex_index <= index;
        vtx.coord_x      <= x;
        vtx.coord_y      <= y;
        vtx.coord_z      <= z;
        vtx.coord_w      <= w;
        vtx.valid        <= 1'b1;
        do
            @(posedge clk);
        while (!(vtx.valid && vtx.ready));
    endtask

    task automatic send_vertex(logic [IDX_W-1:0] index, logic [15:0] x, logic [15:0] y,
                               logic [15:0] z, logic [15:0] w);
        send_word(CMD_VERTEX, index, x, y, z, w, 0);
    endtask

    task automatic send_tick();
        send_word(CMD_TICK, IDX_W'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 0);
    endtask

    // Wait for every result, then let the block settle before touching registers.
    task automatic drain();
        @(negedge clk);
        vtx.valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [15:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_setup(logic [15:0] step, logic [15:0] fov, logic [15:0] scale,
                              logic [15:0] cx, logic [15:0] cy);
        write_reg(CFG_ROTATION_STEP, step);
        write_reg(CFG_FIELD_OF_VIEW, fov);
        write_reg(CFG_PIXEL_SCALE, scale);
        write_reg(CFG_CENTRE_X, cx);
        write_reg(CFG_CENTRE_Y, cy);
    endtask

    // Mostly modest coordinates so the view stays visible, with extremes and full range.
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2, 3:    return 16'($urandom);
            default: return 16'($signed($urandom_range(8192)) - 4096);
        endcase
    endfunction

    // Bursts of words with random gaps between bursts.
    task automatic random_words(int count);
        int burst;
        int gap;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            gap = 0;
            if (burst == 0) begin
                burst = $urandom_range(12, 1);
                gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(600, 1);
            end
            burst--;
            if ($urandom_range(9) < 3)
                send_word(CMD_TICK, IDX_W'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), gap);
            else
                send_word(CMD_VERTEX, IDX_W'($urandom), pick_coord(), pick_coord(),
                          pick_coord(), pick_coord(), gap);
        end
    endtask

    initial begin
        hold_request  = 1'b0;
        idle_cycles   = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        vtx.valid        = 1'b0;
        vtx.cmd          = CMD_VERTEX;
        vtx.vertex_index = '0;
        vtx.coord_x      = '0;
        vtx.coord_y      = '0;
        vtx.coord_z      = '0;
        vtx.coord_w      = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, zero angles, field extremes.
        send_vertex(4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_vertex(4'd15, 16'h1000, 16'hf000, 16'h0800, 16'h0400);
        send_vertex(4'd1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_vertex(4'd2, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
        // Behind the viewer: w pulls the first denominator to zero, then below.
        send_vertex(4'd3, 16'h1000, 16'h1000, 16'h0000, 16'he000);
        send_vertex(4'd4, 16'h1000, 16'h1000, 16'h0000, 16'h8000);
        // Second denominator negative from a large negative z.
        send_vertex(4'd5, 16'h1000, 16'h1000, 16'h8000, 16'h0000);
        send_tick();
        send_vertex(4'd6, 16'h2000, 16'h1000, 16'hf800, 16'h0400);
        send_tick();
        send_tick();
        send_vertex(4'd7, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        drain();

        // Minimum extremes: frozen angles, smallest fov, zero scale lands on the centre.
        load_setup(16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
        send_tick();
        send_vertex(4'd8, 16'h7fff, 16'h8000, 16'h0100, 16'h0000);
        send_vertex(4'd9, 16'h1000, 16'h1000, 16'h1000, 16'h1000);
        drain();

        // Zero field of view: the denominator is just w. Unused indexes are ignored.
        write_reg(CFG_FIELD_OF_VIEW, 16'd0);
        write_reg(3'd5, 16'hffff);
        write_reg(3'd7, 16'h1234);
        write_reg(CFG_PIXEL_SCALE, 16'd25600);
        send_vertex(4'd10, 16'h1000, 16'h1000, 16'h1000, 16'h1000);
        send_vertex(4'd11, 16'h1000, 16'h1000, 16'h1000, 16'hf000);
        drain();

        // Maximum extremes, with a burst of ticks to wrap the phases.
        load_setup(16'hffff, 16'hffff, 16'hffff, 16'd4095, 16'd4095);
        for (int i = 0; i < 5; i++)
            send_tick();
        send_vertex(4'd12, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_vertex(4'd13, 16'h0001, 16'hffff, 16'h0001, 16'hffff);
        drain();

        // Random phases; back pressure mid-run.
        load_setup(16'd100, 16'd512, 16'd25600, 16'd400, 16'd300);
        random_words(RANDOM_WORDS / 4);
        hold_request = 1'b1;
        random_words(RANDOM_WORDS / 4);
        drain();

        load_setup(16'($urandom), 16'($urandom_range(65535, 1)), 16'($urandom),
                   16'($urandom_range(4095)), 16'($urandom_range(4095)));
        random_words(RANDOM_WORDS / 4);
        drain();

        load_setup(16'($urandom), 16'($urandom_range(2048, 16)),
                   16'($urandom_range(65535, 256)), 16'($urandom_range(4095)),
                   16'($urandom_range(4095)));
        random_words(RANDOM_WORDS / 4);
        drain();

        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: sim.f
hdl/rot4p_pkg.sv
hdl/rot4p_if.sv
hdl/rot4p_sine.sv
hdl/rot4p_muldiv.sv
hdl/rotate4d_project_vertex.sv
verif/rot4p_checker.sv
verif/tb_top.sv
